### design/qapm_pkg.sv
// Shared types, constants and helpers for the quad attitude PID mixer.
// No dependencies; imported by qapm_axis and quad_attitude_pid_mixer_core.
package qapm_pkg;

  // Throttle thresholds, in motor counts
  localparam logic [11:0] THR_ACCUM    = 12'd300;
  localparam logic [11:0] THR_LOW      = 12'd200;
  localparam logic [10:0] THR_IMAX_CAP = 11'd1000;

  // Near-level window, raw Q12.4 magnitudes
  localparam logic signed [15:0] TGT_LIMIT = 16'sd5;
  localparam logic signed [15:0] ANG_LIMIT = 16'sd87;

  // Register indexes on the APB port (byte address = 4 * index)
  localparam logic [2:0] REG_ROLL_P   = 3'd0;
  localparam logic [2:0] REG_ROLL_I   = 3'd1;
  localparam logic [2:0] REG_ROLL_D   = 3'd2;
  localparam logic [2:0] REG_PITCH_P  = 3'd3;
  localparam logic [2:0] REG_PITCH_I  = 3'd4;
  localparam logic [2:0] REG_PITCH_D  = 3'd5;
  localparam logic [2:0] REG_POWER_EN = 3'd6;

  // Datapath widths
  localparam int ERR_W   = 17;  // target + angle
  localparam int PROD_W  = 33;  // 17x17 signed product, Q.12
  localparam int TERM_W  = 29;  // product >>> 4, Q.8
  localparam int INTEG_W = 24;  // integral state, Q16.8
  localparam int ISUM_W  = 30;  // integral + i term before clamp
  localparam int PD_W    = 30;  // P + D
  localparam int AXIS_W  = 31;  // P + I + D
  localparam int MSUM_W  = 33;  // throttle +- roll +- pitch, Q.8
  localparam int IMAX_W  = 18;  // integral limit, Q.8

  // Integral control, decided per sample and shared by both axes
  typedef struct packed {
    logic              accum;    // near level and throttle above accumulate threshold
    logic              clear;    // throttle below low threshold
    logic [IMAX_W-1:0] imax_q8;  // clamp magnitude
  } ictl_t;

  // Floor-shift a Q.8 motor sum to counts and saturate to signed 16 bits
  function automatic logic signed [15:0] motor_sat(input logic signed [MSUM_W-1:0] sum);
    logic signed [MSUM_W-9:0] counts;
    begin
      counts = sum[MSUM_W-1:8];
      if (counts > (MSUM_W-8)'(32767)) begin
        motor_sat = 16'sh7fff;
      end else if (counts < -(MSUM_W-8)'(32768)) begin
        motor_sat = 16'sh8000;
      end else begin
        motor_sat = counts[15:0];
      end
    end
  endfunction

endpackage

### design/qapm_axis.sv
// One attitude axis: P, I and D products, then integral update and P + D.
// Depends on qapm_pkg.
module qapm_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load1,
  input  logic                                load2,
  input  logic signed [15:0]                  angle,
  input  logic signed [15:0]                  target,
  input  logic signed [15:0]                  rate,
  input  logic        [15:0]                  p_gain,
  input  logic        [15:0]                  i_gain,
  input  logic        [15:0]                  d_gain,
  input  qapm_pkg::ictl_t                     ictl,
  output logic signed [qapm_pkg::PD_W-1:0]    pd,
  output logic signed [qapm_pkg::INTEG_W-1:0] integral
);
  import qapm_pkg::*;

  logic signed [ERR_W-1:0]   err;
  logic signed [PROD_W-1:0]  err_x, rate_x, pg_x, ig_x, dg_x;
  logic signed [PROD_W-1:0]  p_prod, i_prod, d_prod;
  logic signed [TERM_W-1:0]  p_term, i_term, d_term;
  logic signed [ISUM_W-1:0]  isum, ilim;
  logic signed [INTEG_W-1:0] integral_next;

  assign err    = ERR_W'(angle) + ERR_W'(target);
  assign err_x  = PROD_W'(err);
  assign rate_x = PROD_W'(rate);
  assign pg_x   = PROD_W'($signed({1'b0, p_gain}));
  assign ig_x   = PROD_W'($signed({1'b0, i_gain}));
  assign dg_x   = PROD_W'($signed({1'b0, d_gain}));
  assign p_prod = pg_x * err_x;
  assign i_prod = ig_x * err_x;
  assign d_prod = dg_x * rate_x;

  // Stage 1: products, floor-shifted to Q.8
  always_ff @(posedge clk) begin
    if (load1) begin
      p_term <= TERM_W'(p_prod >>> 4);
      i_term <= TERM_W'(i_prod >>> 4);
      d_term <= TERM_W'(d_prod >>> 4);
    end
  end

  // Integral accumulate with symmetric clamp, else clear or hold
  assign isum = ISUM_W'(integral) + ISUM_W'(i_term);
  assign ilim = ISUM_W'($signed({1'b0, ictl.imax_q8}));

  always_comb begin
    integral_next = integral;
    if (ictl.accum) begin
      if (isum > ilim) begin
        integral_next = INTEG_W'(ilim);
      end else if (isum < -ilim) begin
        integral_next = INTEG_W'(-ilim);
      end else begin
        integral_next = INTEG_W'(isum);
      end
    end else if (ictl.clear) begin
      integral_next = '0;
    end
  end

  // Stage 2: integral state and P + D
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (load2) begin
      integral <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      pd <= PD_W'(p_term) + PD_W'(d_term);
    end
  end

endmodule

### design/quad_attitude_pid_mixer_core.sv
// Top level: roll/pitch PID attitude controller with X-frame motor mixer.
// Depends on qapm_pkg and qapm_axis.

// One attitude sample in, four motor commands out, one transaction per
// clock sustained while out_stall is low. Each sample passes four register
// stages: input capture, gain products, integral update with P + D, and the
// mixer/saturation output register, and out_valid rises once it reaches the
// last of them. The integral recurrence closes in the third stage as one add
// and clamp, which is what lets a new sample follow every cycle.
// Each stage moves forward whenever the stage after it is empty or moving, so
// bubbles collapse and the input keeps taking samples while a finished result
// waits on out_stall, until all four stages hold data. Per axis the error is
// target + angle; P = p_gain * error, D = d_gain * rate, both floor-shifted to
// Q.8. The integrals accumulate i_gain * error, clamped to
// +-min(throttle / 2, 1000) counts, only near level (|target| <= 5 raw,
// |angle| <= 87 raw) with throttle above 300; they clear when throttle is
// under 200 and hold otherwise. Motor commands are zero at throttle 200 or
// below or while power_enable is 0; the integrals update regardless.
// Gains and power_enable sit on an APB port at byte address 4 * index and
// are meant to be written while no transaction is in flight.
module quad_attitude_pid_mixer_core (
  input  logic               clk,
  input  logic               rst,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // attitude sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_target,
  input  logic signed [15:0] pitch_target,
  input  logic signed [15:0] roll_rate,
  input  logic signed [15:0] pitch_rate,
  input  logic        [11:0] throttle,
  // motor command channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] motor_front_a,
  output logic signed [15:0] motor_front_b,
  output logic signed [15:0] motor_rear_a,
  output logic signed [15:0] motor_rear_b
);
  import qapm_pkg::*;

  // ---------------- configuration registers ----------------
  logic [15:0] roll_p_gain, roll_i_gain, roll_d_gain;
  logic [15:0] pitch_p_gain, pitch_i_gain, pitch_d_gain;
  logic        power_enable;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_p_gain  <= 16'd256;
      roll_i_gain  <= 16'd0;
      roll_d_gain  <= 16'd26;
      pitch_p_gain <= 16'd1536;
      pitch_i_gain <= 16'd0;
      pitch_d_gain <= 16'd205;
      power_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROLL_P:   roll_p_gain  <= pwdata[15:0];
        REG_ROLL_I:   roll_i_gain  <= pwdata[15:0];
        REG_ROLL_D:   roll_d_gain  <= pwdata[15:0];
        REG_PITCH_P:  pitch_p_gain <= pwdata[15:0];
        REG_PITCH_I:  pitch_i_gain <= pwdata[15:0];
        REG_PITCH_D:  pitch_d_gain <= pwdata[15:0];
        REG_POWER_EN: power_enable <= pwdata[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROLL_P:   prdata = {16'd0, roll_p_gain};
      REG_ROLL_I:   prdata = {16'd0, roll_i_gain};
      REG_ROLL_D:   prdata = {16'd0, roll_d_gain};
      REG_PITCH_P:  prdata = {16'd0, pitch_p_gain};
      REG_PITCH_I:  prdata = {16'd0, pitch_i_gain};
      REG_PITCH_D:  prdata = {16'd0, pitch_d_gain};
      REG_POWER_EN: prdata = {31'd0, power_enable};
      default:      prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // Stage valids; each stage is free when empty or when its content moves on.
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;
  logic load0, load1, load2, load3;

  assign rdy3  = ~v3 | ~out_stall;
  assign rdy2  = ~v2 | rdy3;
  assign rdy1  = ~v1 | rdy2;
  assign rdy0  = ~v0 | rdy1;
  assign load0 = in_valid & rdy0;
  assign load1 = v0 & rdy1;
  assign load2 = v1 & rdy2;
  assign load3 = v2 & rdy3;

  assign in_stall  = ~rdy0;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // ---------------- stage 0: input capture ----------------
  logic signed [15:0] s0_roll_ang, s0_pitch_ang, s0_roll_tgt, s0_pitch_tgt;
  logic signed [15:0] s0_roll_rate, s0_pitch_rate;
  logic        [11:0] s0_thr;

  always_ff @(posedge clk) begin
    if (load0) begin
      s0_roll_ang   <= roll_angle;
      s0_pitch_ang  <= pitch_angle;
      s0_roll_tgt   <= roll_target;
      s0_pitch_tgt  <= pitch_target;
      s0_roll_rate  <= roll_rate;
      s0_pitch_rate <= pitch_rate;
      s0_thr        <= throttle;
    end
  end

  // ---------------- stage 1: flags and limit ----------------
  logic        level;
  logic [10:0] thr_half;
  logic [9:0]  imax;
  ictl_t       ictl_next, s1_ictl;
  logic        s1_drive, s2_drive;
  logic [11:0] s1_thr, s2_thr;

  assign level = (s0_roll_tgt  >= -TGT_LIMIT) && (s0_roll_tgt  <= TGT_LIMIT) &&
                 (s0_pitch_tgt >= -TGT_LIMIT) && (s0_pitch_tgt <= TGT_LIMIT) &&
                 (s0_roll_ang  >= -ANG_LIMIT) && (s0_roll_ang  <= ANG_LIMIT) &&
                 (s0_pitch_ang >= -ANG_LIMIT) && (s0_pitch_ang <= ANG_LIMIT);

  assign thr_half = s0_thr[11:1];
  assign imax     = (thr_half > THR_IMAX_CAP) ? THR_IMAX_CAP[9:0] : thr_half[9:0];

  always_comb begin
    ictl_next.accum   = level && (s0_thr > THR_ACCUM);
    ictl_next.clear   = s0_thr < THR_LOW;
    ictl_next.imax_q8 = {imax, 8'd0};
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_ictl  <= ictl_next;
      s1_drive <= s0_thr > THR_LOW;
      s1_thr   <= s0_thr;
    end
  end

  // ---------------- axes (stages 1 and 2) ----------------
  logic signed [PD_W-1:0]    roll_pd, pitch_pd;
  logic signed [INTEG_W-1:0] roll_integral, pitch_integral;

  qapm_axis u_roll (
    .clk      (clk),
    .rst      (rst),
    .load1    (load1),
    .load2    (load2),
    .angle    (s0_roll_ang),
    .target   (s0_roll_tgt),
    .rate     (s0_roll_rate),
    .p_gain   (roll_p_gain),
    .i_gain   (roll_i_gain),
    .d_gain   (roll_d_gain),
    .ictl     (s1_ictl),
    .pd       (roll_pd),
    .integral (roll_integral)
  );

  qapm_axis u_pitch (
    .clk      (clk),
    .rst      (rst),
    .load1    (load1),
    .load2    (load2),
    .angle    (s0_pitch_ang),
    .target   (s0_pitch_tgt),
    .rate     (s0_pitch_rate),
    .p_gain   (pitch_p_gain),
    .i_gain   (pitch_i_gain),
    .d_gain   (pitch_d_gain),
    .ictl     (s1_ictl),
    .pd       (pitch_pd),
    .integral (pitch_integral)
  );

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_drive <= s1_drive;
      s2_thr   <= s1_thr;
    end
  end

  // ---------------- stage 3: mixer and output register ----------------
  // The integral registers hold this stage-2 transaction's updated value
  // until the next transaction enters stage 2, no earlier than the edge that loads this stage.
  logic signed [AXIS_W-1:0] roll_out, pitch_out;
  logic signed [MSUM_W-1:0] base, sum_fa, sum_fb, sum_ra, sum_rb;
  logic                     motors_on;

  assign roll_out  = AXIS_W'(roll_pd)  + AXIS_W'(roll_integral);
  assign pitch_out = AXIS_W'(pitch_pd) + AXIS_W'(pitch_integral);
  assign base      = MSUM_W'($signed({1'b0, s2_thr, 8'd0}));
  assign sum_fa    = base - MSUM_W'(roll_out) + MSUM_W'(pitch_out);
  assign sum_fb    = base - MSUM_W'(roll_out) - MSUM_W'(pitch_out);
  assign sum_ra    = base + MSUM_W'(roll_out) - MSUM_W'(pitch_out);
  assign sum_rb    = base + MSUM_W'(roll_out) + MSUM_W'(pitch_out);
  assign motors_on = s2_drive & power_enable;

  always_ff @(posedge clk) begin
    if (load3) begin
      motor_front_a <= motors_on ? motor_sat(sum_fa) : 16'sd0;
      motor_front_b <= motors_on ? motor_sat(sum_fb) : 16'sd0;
      motor_rear_a  <= motors_on ? motor_sat(sum_ra) : 16'sd0;
      motor_rear_b  <= motors_on ? motor_sat(sum_rb) : 16'sd0;
    end
  end

endmodule
